@@ hw/rtl/lcdts_pkg.sv @@
// Shared types and timing constants for the LCD line timing and status block.
`timescale 1ns / 1ps
package lcdts_pkg;

  localparam int unsigned DotW  = 10;
  localparam int unsigned LineW = 8;
  localparam int unsigned CfgW  = 8;

  localparam logic [DotW-1:0]  DotsPerLine = 10'd456;
  localparam logic [DotW-1:0]  OamEnd      = 10'd80;
  localparam logic [DotW-1:0]  DrawEnd     = 10'd252;
  localparam logic [LineW-1:0] LastLine    = 8'd153;
  localparam logic [LineW-1:0] VblankLine  = 8'd144;

  // LCD mode codes
  localparam logic [1:0] ModeHblank = 2'd0;
  localparam logic [1:0] ModeVblank = 2'd1;
  localparam logic [1:0] ModeOam    = 2'd2;
  localparam logic [1:0] ModeDraw   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CfgLcdEnable   = 2'd0;
  localparam logic [1:0] CfgCompareLine = 2'd1;
  localparam logic [1:0] CfgIrqEnables  = 2'd2;

  // Status interrupt enable bit positions
  localparam int unsigned IrqHblank = 0;
  localparam int unsigned IrqVblank = 1;
  localparam int unsigned IrqOam    = 2;
  localparam int unsigned IrqCoin   = 3;

  typedef struct packed {
    logic             lcd_enable;
    logic [LineW-1:0] compare_line;
    logic [3:0]       irq_enables;
  } cfg_t;

  typedef struct packed {
    logic [DotW-1:0]  dot_count;
    logic [LineW-1:0] line_count;
    logic [1:0]       mode_bits;
    logic             coin_flag;
  } timing_t;

  // Packed in output order, line number in the lowest bits.
  typedef struct packed {
    logic             hblank_start;
    logic             line_start;
    logic             frame_done;
    logic             status_request;
    logic             vblank_request;
    logic             coincidence;
    logic [1:0]       lcd_mode;
    logic [LineW-1:0] line_number;
  } result_t;

endpackage

@@ hw/rtl/lcdts_step.sv @@
// Next-state and result logic for one timing item.
`timescale 1ns / 1ps
module lcdts_step (
  input  lcdts_pkg::cfg_t    cfg_i,
  input  lcdts_pkg::timing_t state_i,
  input  logic [7:0]         elapsed_i,
  output lcdts_pkg::timing_t state_o,
  output lcdts_pkg::result_t result_o
);

  logic [lcdts_pkg::DotW-1:0]  dot_sum;
  logic                        wrap;
  logic [lcdts_pkg::LineW-1:0] line_inc;
  logic                        visible;
  logic [1:0]                  mode_mid;
  logic                        vblank, status, lstart, hstart;
  lcdts_pkg::timing_t          nxt;

  always_comb begin
    nxt      = state_i;
    vblank   = 1'b0;
    status   = 1'b0;
    lstart   = 1'b0;
    hstart   = 1'b0;
    // state below 456 plus at most 255 never overflows ten bits
    dot_sum  = state_i.dot_count + {2'b00, elapsed_i};
    wrap     = dot_sum >= lcdts_pkg::DotsPerLine;
    line_inc = state_i.line_count + 8'd1;
    if (line_inc > lcdts_pkg::LastLine) begin
      line_inc = '0;
    end
    mode_mid = state_i.mode_bits;
    visible  = 1'b0;

    if (cfg_i.lcd_enable) begin
      nxt.dot_count = wrap ? dot_sum - lcdts_pkg::DotsPerLine : dot_sum;
      if (wrap) begin
        nxt.line_count = line_inc;
        if (line_inc == lcdts_pkg::VblankLine) begin
          mode_mid = lcdts_pkg::ModeVblank;
          vblank   = 1'b1;
          status   = status | cfg_i.irq_enables[lcdts_pkg::IrqVblank];
        end else if (line_inc < lcdts_pkg::VblankLine) begin
          mode_mid = lcdts_pkg::ModeOam;
          lstart   = 1'b1;
          status   = status | cfg_i.irq_enables[lcdts_pkg::IrqOam];
        end
        nxt.coin_flag = (line_inc == cfg_i.compare_line);
        if (line_inc == cfg_i.compare_line) begin
          status = status | cfg_i.irq_enables[lcdts_pkg::IrqCoin];
        end
      end
      nxt.mode_bits = mode_mid;
      visible = nxt.line_count < lcdts_pkg::VblankLine;
      if (visible) begin
        if (nxt.dot_count < lcdts_pkg::OamEnd) begin
          nxt.mode_bits = lcdts_pkg::ModeOam;
        end else if (nxt.dot_count < lcdts_pkg::DrawEnd) begin
          nxt.mode_bits = lcdts_pkg::ModeDraw;
        end else begin
          if (mode_mid != lcdts_pkg::ModeHblank) begin
            hstart = 1'b1;
            status = status | cfg_i.irq_enables[lcdts_pkg::IrqHblank];
          end
          nxt.mode_bits = lcdts_pkg::ModeHblank;
        end
      end
    end
  end

  assign state_o = nxt;

  always_comb begin
    result_o.line_number    = nxt.line_count;
    result_o.lcd_mode       = nxt.mode_bits;
    result_o.coincidence    = nxt.coin_flag;
    result_o.vblank_request = vblank;
    result_o.status_request = status;
    result_o.frame_done     = vblank;
    result_o.line_start     = lstart;
    result_o.hblank_start   = hstart;
  end

endmodule

@@ hw/rtl/lcd_line_timing_status_core.sv @@
// LCD line timing and status core: top level with input, state and result registers.
//
// Usage: each item on the slave stream carries the machine cycles elapsed since
// the previous item. With the display enabled, the cycles are added to the dot
// counter, lines advance every 456 dots (wrapping after line 153), and the mode,
// coincidence flag and interrupt/strobe pulses are produced; one result item per
// input item on the master stream. With the display disabled the state holds
// and the result repeats it with all pulses zero.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while idle:
// index 0 display enable, 1 compare line, 2 status interrupt enables.
// An accepted item goes into the input register; the state and result registers are
// then updated together from it. Throughput: one item per cycle while the receiver
// keeps taking results, set by the dot/line update loop on the state registers.
// When the receiver stalls, the result register holds and the input register
// takes one more item; then s_axis_tready drops until the result is taken.
// Reset clears the timing state to line 0, dot 0, hblank, enables the display
// and clears the compare line and interrupt enables; both registers go empty.
`timescale 1ns / 1ps
module lcd_line_timing_status_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] elapsed_cycles
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] line_number, [9:8] lcd_mode, [10] coincidence, [11] vblank_request,
  // [12] status_request, [13] frame_done, [14] line_start, [15] hblank_start
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [lcdts_pkg::CfgW-1:0] cfg_wdata_i
);

  lcdts_pkg::cfg_t    cfg_q;
  lcdts_pkg::timing_t state_q, state_d;
  lcdts_pkg::result_t result_d, result_q;
  logic               in_valid_q, out_valid_q;
  logic [7:0]         in_data_q;
  logic               out_free, advance;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lcd_enable   <= 1'b1;
      cfg_q.compare_line <= '0;
      cfg_q.irq_enables  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcdts_pkg::CfgLcdEnable:   cfg_q.lcd_enable   <= cfg_wdata_i[0];
        lcdts_pkg::CfgCompareLine: cfg_q.compare_line <= cfg_wdata_i[lcdts_pkg::LineW-1:0];
        lcdts_pkg::CfgIrqEnables:  cfg_q.irq_enables  <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
    end
  end

  lcdts_step u_step (
    .cfg_i     (cfg_q),
    .state_i   (state_q),
    .elapsed_i (in_data_q),
    .state_o   (state_d),
    .result_o  (result_d)
  );

  // state and result advance together, once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = result_q;

endmodule

@@ hw/rtl/lcdts_checker.sv @@
// Port-level checks on the result stream of the LCD line timing core.
`timescale 1ns / 1ps
module lcdts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic [15:0] m_axis_tdata
);

  // frame done and vblank request are the same event
  a_frame_vblank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[13] == m_axis_tdata[11]))
    else $error("frame_done and vblank_request differ");

  a_frame_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[13]) |->
      (m_axis_tdata[7:0] == 8'd144 && m_axis_tdata[9:8] == lcdts_pkg::ModeVblank))
    else $error("frame_done outside line 144 vblank");

  // leftover dots may put a fresh line straight into any visible mode
  a_line_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[14]) |->
      (m_axis_tdata[7:0] < 8'd144 && m_axis_tdata[9:8] != lcdts_pkg::ModeVblank))
    else $error("line_start on a non-visible line");

  a_hblank_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[15]) |-> (m_axis_tdata[9:8] == lcdts_pkg::ModeHblank))
    else $error("hblank_start without hblank mode");

  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] <= 8'd153))
    else $error("line number out of range");

endmodule

bind lcd_line_timing_status_core lcdts_checker u_lcdts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tdata  (m_axis_tdata)
);

@@ verif/lcd_timing_checker.sv @@
// Checker for the LCD line timing core: predicts each result item and compares it.
`timescale 1ns / 1ps
module lcd_timing_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] elapsed_cycles
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [7:0] line_number, [9:8] lcd_mode, [10] coincidence, [11] vblank_request,
  // [12] status_request, [13] frame_done, [14] line_start, [15] hblank_start
  input  logic [15:0]                m_axis_tdata,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [lcdts_pkg::CfgW-1:0] cfg_wdata_i,
  output int                         errors_o,
  output int                         outstanding_o,
  output int                         results_o,
  output int                         frames_o,
  output int                         status_hits_o
);

  lcdts_pkg::cfg_t    cfg;
  lcdts_pkg::timing_t timing;
  lcdts_pkg::result_t expected_q[$];

  task automatic report_fail(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors_o++;
  endtask

  // Advance the timing state by one item and return the result it should give.
  function automatic lcdts_pkg::result_t predict_step(input logic [7:0] cycles);
    lcdts_pkg::result_t r;
    r = '0;
    if (cfg.lcd_enable) begin
      timing.dot_count = timing.dot_count + lcdts_pkg::DotW'(cycles);
      if (timing.dot_count >= lcdts_pkg::DotsPerLine) begin
        timing.dot_count  = timing.dot_count - lcdts_pkg::DotsPerLine;
        timing.line_count = (timing.line_count >= lcdts_pkg::LastLine) ?
                            '0 : timing.line_count + 1'b1;
        if (timing.line_count == lcdts_pkg::VblankLine) begin
          timing.mode_bits   = lcdts_pkg::ModeVblank;
          r.vblank_request   = 1'b1;
          r.frame_done       = 1'b1;
          if (cfg.irq_enables[lcdts_pkg::IrqVblank]) r.status_request = 1'b1;
        end else if (timing.line_count < lcdts_pkg::VblankLine) begin
          timing.mode_bits = lcdts_pkg::ModeOam;
          r.line_start     = 1'b1;
          if (cfg.irq_enables[lcdts_pkg::IrqOam]) r.status_request = 1'b1;
        end
        timing.coin_flag = (timing.line_count == cfg.compare_line);
        if (timing.coin_flag && cfg.irq_enables[lcdts_pkg::IrqCoin]) r.status_request = 1'b1;
      end
      // Visible lines follow the dot count; a line start may land straight in hblank
      if (timing.line_count < lcdts_pkg::VblankLine) begin
        if (timing.dot_count < lcdts_pkg::OamEnd) begin
          timing.mode_bits = lcdts_pkg::ModeOam;
        end else if (timing.dot_count < lcdts_pkg::DrawEnd) begin
          timing.mode_bits = lcdts_pkg::ModeDraw;
        end else begin
          if (timing.mode_bits != lcdts_pkg::ModeHblank) begin
            r.hblank_start = 1'b1;
            if (cfg.irq_enables[lcdts_pkg::IrqHblank]) r.status_request = 1'b1;
          end
          timing.mode_bits = lcdts_pkg::ModeHblank;
        end
      end
    end
    r.line_number = timing.line_count;
    r.lcd_mode    = timing.mode_bits;
    r.coincidence = timing.coin_flag;
    return r;
  endfunction

  task automatic compare_result(input lcdts_pkg::result_t got, input lcdts_pkg::result_t want);
    if (got.line_number != want.line_number)
      report_fail($sformatf("line_number got %0d want %0d", got.line_number, want.line_number));
    if (got.lcd_mode != want.lcd_mode)
      report_fail($sformatf("lcd_mode got %0d want %0d", got.lcd_mode, want.lcd_mode));
    if (got.coincidence != want.coincidence)
      report_fail($sformatf("coincidence got %0b want %0b", got.coincidence, want.coincidence));
    if (got.vblank_request != want.vblank_request)
      report_fail($sformatf("vblank_request got %0b want %0b",
                            got.vblank_request, want.vblank_request));
    if (got.status_request != want.status_request)
      report_fail($sformatf("status_request got %0b want %0b",
                            got.status_request, want.status_request));
    if (got.frame_done != want.frame_done)
      report_fail($sformatf("frame_done got %0b want %0b", got.frame_done, want.frame_done));
    if (got.line_start != want.line_start)
      report_fail($sformatf("line_start got %0b want %0b", got.line_start, want.line_start));
    if (got.hblank_start != want.hblank_start)
      report_fail($sformatf("hblank_start got %0b want %0b",
                            got.hblank_start, want.hblank_start));
    results_o++;
    if (want.frame_done) frames_o++;
    if (want.status_request) status_hits_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.lcd_enable   = 1'b1;
      cfg.compare_line = '0;
      cfg.irq_enables  = '0;
      timing           = '0;
      expected_q.delete();
      errors_o         = 0;
      results_o        = 0;
      frames_o         = 0;
      status_hits_o    = 0;
      outstanding_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lcdts_pkg::CfgLcdEnable:   cfg.lcd_enable   = cfg_wdata_i[0];
          lcdts_pkg::CfgCompareLine: cfg.compare_line = cfg_wdata_i[lcdts_pkg::LineW-1:0];
          lcdts_pkg::CfgIrqEnables:  cfg.irq_enables  = cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(predict_step(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0)
          report_fail($sformatf("result item %h with nothing expected", m_axis_tdata));
        else
          compare_result(lcdts_pkg::result_t'(m_axis_tdata), expected_q.pop_front());
      end
      outstanding_o <= expected_q.size();
    end
  end

endmodule

@@ verif/tb_lcd_line_timing_status_core.sv @@
// Testbench top for the LCD line timing core: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_lcd_line_timing_status_core;

  localparam logic [1:0]  CfgUnused     = 2'd3;
  localparam int unsigned Rounds        = 6;
  localparam int unsigned ItemsPerRound = 80;
  localparam int unsigned StallCycles   = 60;
  localparam int unsigned QuietLimit    = 3000;
  localparam int unsigned DrainCycles   = 8;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [7:0]                 s_axis_tdata;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [15:0]                m_axis_tdata;
  logic                       cfg_we_i;
  logic [1:0]                 cfg_idx_i;
  logic [lcdts_pkg::CfgW-1:0] cfg_wdata_i;

  int   tx_idle_pct;
  int   rx_idle_pct;
  logic stall_burst_req;
  logic stall_burst_done;
  int   quiet_cycles;

  int errors;
  int outstanding;
  int results;
  int frames;
  int status_hits;

  // Walk the dot count across mode edges, then a line start that lands in hblank
  logic [7:0] dot_walk [15] = '{8'd1, 8'd171, 8'd1, 8'd203, 8'd1, 8'd255, 8'd200, 8'd255,
                                8'd0, 8'd255, 8'd255, 8'd147, 8'd255, 8'd0, 8'd255};

  lcd_line_timing_status_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  lcd_timing_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .errors_o      (errors),
    .outstanding_o (outstanding),
    .results_o     (results),
    .frames_o      (frames),
    .status_hits_o (status_hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mostly near-full ticks so the run crosses vblank and wraps the frame
  function automatic logic [7:0] pick_cycles();
    case ($urandom_range(9))
      0:       return 8'($urandom_range(255));
      1:       return 8'($urandom_range(3));
      default: return 8'($urandom_range(255, 224));
    endcase
  endfunction

  task automatic send_tick(input logic [7:0] cycles);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cycles;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // Write every register, unused index first, with junk in the bits above each width
  task automatic write_settings(input logic en, input logic [7:0] cmp, input logic [3:0] irq);
    logic [lcdts_pkg::CfgW-1:0] noise;
    noise = lcdts_pkg::CfgW'($urandom);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgUnused;
    cfg_wdata_i <= noise;
    @(posedge clk_i);
    cfg_idx_i   <= lcdts_pkg::CfgLcdEnable;
    cfg_wdata_i <= {noise[lcdts_pkg::CfgW-1:1], en};
    @(posedge clk_i);
    cfg_idx_i   <= lcdts_pkg::CfgCompareLine;
    cfg_wdata_i <= cmp;
    @(posedge clk_i);
    cfg_idx_i   <= lcdts_pkg::CfgIrqEnables;
    cfg_wdata_i <= {noise[lcdts_pkg::CfgW-1:4], irq};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Receiver: random back-pressure, plus one long hold on request
  initial begin
    m_axis_tready   <= 1'b0;
    stall_burst_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_burst_req && !stall_burst_done) begin
        m_axis_tready <= 1'b0;
        repeat (StallCycles) @(posedge clk_i);
        stall_burst_done = 1'b1;
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("Watchdog: no item moved for %0d cycles", QuietLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] cmp;
    logic [3:0] irq;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= lcdts_pkg::CfgLcdEnable;
    cfg_wdata_i    <= '0;
    rst_ni         <= 1'b0;
    tx_idle_pct     = 0;
    rx_idle_pct     = 0;
    stall_burst_req = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: display on, compare line 0, no interrupts
    send_tick(8'd0);
    send_tick(8'd79);
    wait_drained();
    write_settings(1'b1, 8'd2, 4'hF);
    foreach (dot_walk[i]) send_tick(dot_walk[i]);
    wait_drained();
    // Display off: state must hold and pulses stay low
    write_settings(1'b0, 8'd2, 4'hF);
    send_tick(8'd255);
    send_tick(8'd128);
    send_tick(8'd0);
    send_tick(8'd255);

    for (int r = 0; r < Rounds; r++) begin
      wait_drained();
      case (r)
        0:       begin cmp = 8'd0;   irq = 4'hF; end
        1:       begin cmp = 8'd255; irq = 4'h0; end
        2:       begin cmp = 8'd144; irq = 4'b1010; end
        3:       begin cmp = 8'd153; irq = 4'b0101; end
        default: begin cmp = 8'($urandom_range(153)); irq = 4'($urandom); end
      endcase
      if (r < 2) begin
        tx_idle_pct = 24;
        rx_idle_pct = 79;
      end else if (r < 4) begin
        tx_idle_pct = 79;
        rx_idle_pct = 24;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (r == 3) begin
        write_settings(1'b0, cmp, irq);
        repeat (8) send_tick(pick_cycles());
        wait_drained();
      end
      write_settings(1'b1, cmp, irq);
      // Hold the receiver off while items keep coming, so the input stalls
      if (r == 4) stall_burst_req = 1'b1;
      for (int n = 0; n < ItemsPerRound; n++) begin
        if (r == 1 && n == ItemsPerRound / 2) wait_drained();
        send_tick(pick_cycles());
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Checked %0d result items: %0d frame ends, %0d status requests.",
             results, frames, status_hits);
    $display("Covered dot and line edges, display off, six interrupt and compare settings.");
    if (errors == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ lcd_line_timing_status_core.f @@
hw/rtl/lcdts_pkg.sv
hw/rtl/lcdts_step.sv
hw/rtl/lcd_line_timing_status_core.sv
hw/rtl/lcdts_checker.sv
verif/lcd_timing_checker.sv
verif/tb_lcd_line_timing_status_core.sv
